// ----- hw/rtl/srcq_pkg.sv -----
package srcq_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 32;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int COUNT_WIDTH_DEF    = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int MODE_W     = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_CAP = 5'd30;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 32'h0001_0000;

  localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHR   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SCALE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BIAS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_BIAS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_CEIL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BITS = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [SHIFT_W-1:0]    shift_amount;
    logic [GAIN_W-1:0]     gain_q16;
    logic [CFG_DATA_W-1:0] src_bias;
    logic [CFG_DATA_W-1:0] dst_bias;
    logic [CFG_DATA_W-1:0] code_floor;
    logic [CFG_DATA_W-1:0] code_ceil;
    logic [SHIFT_W-1:0]    quant_bits;
  } cfg_t;

  function automatic logic [SHIFT_W-1:0] cap_shift(input logic [SHIFT_W-1:0] s);
    cap_shift = (s > SHIFT_CAP) ? SHIFT_CAP : s;
  endfunction

endpackage

// ----- hw/rtl/sample_rescale_clip_quantize_unit.sv -----
// Input register, two rescale stages, a clip stage, two quantize stages.
// One sample per cycle unless stalled; six register stages, one multiplier
// (SAMPLE_WIDTH x 32) between the input register and the second stage.
// Reset (rst, synchronous): empties the pipeline, clears the clip counter
// and loads the register defaults; payload registers are not reset.
module sample_rescale_clip_quantize_unit #(
  parameter int SAMPLE_WIDTH   = srcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = srcq_pkg::GAIN_FRAC_BITS_DEF,
  parameter int COUNT_WIDTH    = srcq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  logic                                block_end,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  output logic                                was_clipped,
  output logic [COUNT_WIDTH-1:0]              clip_total,
  output logic                                block_end_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srcq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srcq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import srcq_pkg::*;

  localparam int NumStages = 6;
  localparam int W  = SAMPLE_WIDTH;
  localparam int VW = W + 32;
  localparam logic [CFG_DATA_W-1:0] MinReset = CFG_DATA_W'(1) << (W - 1);
  localparam logic [CFG_DATA_W-1:0] MaxReset = MinReset - CFG_DATA_W'(1);

  cfg_t cfg;

  logic [NumStages-1:0] valid;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] ld;

  logic signed [W-1:0]  s0_sample;
  logic                 s0_end;
  logic signed [VW-1:0] s2_v;
  logic                 s2_end;
  logic signed [W-1:0]  s3_c;
  logic                 s3_clipped;
  logic [COUNT_WIDTH-1:0] s3_total;
  logic                 s3_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_COPY;
      cfg.shift_amount <= '0;
      cfg.gain_q16     <= GAIN_RESET;
      cfg.src_bias     <= '0;
      cfg.dst_bias     <= '0;
      cfg.code_floor   <= MinReset;
      cfg.code_ceil    <= MaxReset;
      cfg.quant_bits   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:       cfg.mode         <= cfg_data[MODE_W-1:0];
        CFG_SHIFT:      cfg.shift_amount <= cfg_data[SHIFT_W-1:0];
        CFG_GAIN:       cfg.gain_q16     <= cfg_data[GAIN_W-1:0];
        CFG_SRC_BIAS:   cfg.src_bias     <= cfg_data;
        CFG_DST_BIAS:   cfg.dst_bias     <= cfg_data;
        CFG_CODE_FLOOR: cfg.code_floor   <= cfg_data;
        CFG_CODE_CEIL:  cfg.code_ceil    <= cfg_data;
        CFG_QUANT_BITS: cfg.quant_bits   <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  always_comb begin
    rdy[NumStages-1] = !valid[NumStages-1] || !result_stall;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign ld           = rdy & {valid[NumStages-2:0], sample_valid};
  assign sample_stall = !rdy[0];
  assign result_valid = valid[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          valid[k] <= (k == 0) ? sample_valid : valid[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_sample <= sample_in;
      s0_end    <= block_end;
    end
  end

  srcq_rescale #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_rescale (
    .clk    (clk),
    .ld     (ld[2:1]),
    .sample (s0_sample),
    .end_in (s0_end),
    .cfg    (cfg),
    .v      (s2_v),
    .end_out(s2_end)
  );

  srcq_clip #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_clip (
    .clk    (clk),
    .rst    (rst),
    .ld     (ld[3]),
    .v_in   (s2_v),
    .end_in (s2_end),
    .cfg    (cfg),
    .c      (s3_c),
    .clipped(s3_clipped),
    .total  (s3_total),
    .end_out(s3_end)
  );

  srcq_quant #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_quant (
    .clk        (clk),
    .ld         (ld[5:4]),
    .c_in       (s3_c),
    .clipped_in (s3_clipped),
    .total_in   (s3_total),
    .end_in     (s3_end),
    .cfg        (cfg),
    .sample_out (sample_out),
    .clipped_out(was_clipped),
    .total_out  (clip_total),
    .end_out    (block_end_out)
  );

endmodule

// ----- hw/rtl/srcq_rescale.sv -----
module srcq_rescale #(
  parameter int SAMPLE_WIDTH   = srcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = srcq_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic [1:0]                          ld,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  logic                                end_in,
  input  srcq_pkg::cfg_t                      cfg,
  output logic signed [SAMPLE_WIDTH+31:0]     v,
  output logic                                end_out
);
  import srcq_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int DW = W + 1;
  localparam int VW = W + 32;
  localparam int PW = W + GAIN_W;
  localparam int QW = PW - F + 1;
  localparam logic [F-1:0] Half = F'(1) << (F - 1);

  logic signed [W-1:0]  src_z;
  logic signed [DW-1:0] d;
  logic signed [DW-1:0] mag_full;
  logic [W-1:0]         mag;
  logic [SHIFT_W-1:0]   sh;
  logic signed [VW-1:0] d_ext;
  logic signed [VW-1:0] rnd;
  logic signed [VW-1:0] v_shl;
  logic signed [VW-1:0] v_shr;
  logic signed [VW-1:0] v_pre_next;
  logic [PW-1:0]        prod_next;

  logic signed [VW-1:0] v_pre;
  logic [PW-1:0]        prod;
  logic                 neg;
  logic                 end1;

  logic [PW-F-1:0]      q;
  logic [F-1:0]         rb;
  logic                 up;
  logic [QW-1:0]        qr;
  logic signed [VW-1:0] q_s;
  logic signed [VW-1:0] scaled;
  logic signed [VW-1:0] dz;
  logic signed [VW-1:0] v_next;

  assign src_z    = $signed(cfg.src_bias[W-1:0]);
  assign d        = DW'(sample) - DW'(src_z);
  assign sh       = cap_shift(cfg.shift_amount);
  assign d_ext    = VW'(d);
  assign rnd      = (sh == '0) ? '0 : (VW'(1) << (sh - SHIFT_W'(1)));
  assign v_shl    = d_ext <<< sh;
  assign v_shr    = (d_ext + rnd) >>> sh;
  assign mag_full = d[DW-1] ? -d : d;
  assign mag      = mag_full[W-1:0];
  assign prod_next = PW'(mag) * PW'(cfg.gain_q16);

  always_comb begin
    case (cfg.mode)
      MODE_SHL:   v_pre_next = v_shl;
      MODE_SHR:   v_pre_next = v_shr;
      MODE_COPY:  v_pre_next = d_ext;
      MODE_SCALE: v_pre_next = d_ext;
      default:    v_pre_next = d_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      v_pre <= v_pre_next;
      prod  <= prod_next;
      neg   <= d[DW-1];
      end1  <= end_in;
    end
  end

  // round half to even on the magnitude
  assign q      = prod[PW-1:F];
  assign rb     = prod[F-1:0];
  assign up     = (rb > Half) || ((rb == Half) && q[0]);
  assign qr     = QW'(q) + QW'(up);
  assign q_s    = $signed(VW'(qr));
  assign scaled = neg ? -q_s : q_s;
  assign dz     = VW'($signed(cfg.dst_bias[W-1:0]));
  assign v_next = ((cfg.mode == MODE_SCALE) ? scaled : v_pre) + dz;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      v       <= v_next;
      end_out <= end1;
    end
  end

endmodule

// ----- hw/rtl/srcq_clip.sv -----
module srcq_clip #(
  parameter int SAMPLE_WIDTH = srcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = srcq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ld,
  input  logic signed [SAMPLE_WIDTH+31:0] v_in,
  input  logic                            end_in,
  input  srcq_pkg::cfg_t                  cfg,
  output logic signed [SAMPLE_WIDTH-1:0]  c,
  output logic                            clipped,
  output logic [COUNT_WIDTH-1:0]          total,
  output logic                            end_out
);
  import srcq_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int VW = W + 32;

  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] lo;
  logic                 above;
  logic                 below;
  logic signed [W-1:0]  c_next;
  logic                 clip_next;
  logic [COUNT_WIDTH-1:0] count;

  assign hi        = VW'($signed(cfg.code_ceil[W-1:0]));
  assign lo        = VW'($signed(cfg.code_floor[W-1:0]));
  assign above     = v_in > hi;
  assign below     = v_in < lo;
  assign clip_next = above || below;
  assign c_next    = above ? hi[W-1:0] : (below ? lo[W-1:0] : v_in[W-1:0]);

  // saturate at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ld && clip_next && !(&count)) begin
      count <= count + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      c       <= c_next;
      clipped <= clip_next;
      end_out <= end_in;
    end
  end

  assign total = count;

endmodule

// ----- hw/rtl/srcq_quant.sv -----
module srcq_quant #(
  parameter int SAMPLE_WIDTH = srcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = srcq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic [1:0]                     ld,
  input  logic signed [SAMPLE_WIDTH-1:0] c_in,
  input  logic                           clipped_in,
  input  logic [COUNT_WIDTH-1:0]         total_in,
  input  logic                           end_in,
  input  srcq_pkg::cfg_t                 cfg,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clipped_out,
  output logic [COUNT_WIDTH-1:0]         total_out,
  output logic                           end_out
);
  import srcq_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int VW = W + 32;

  logic [SHIFT_W-1:0]   db;
  logic signed [VW-1:0] low_mask;
  logic signed [VW-1:0] keep;
  logic signed [VW-1:0] half_q;
  logic signed [VW-1:0] dz;
  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] lo;
  logic signed [VW-1:0] off;
  logic signed [VW-1:0] r_next;
  logic signed [VW-1:0] t_hi;
  logic signed [VW-1:0] t_lo;
  logic signed [VW-1:0] tq_hi;
  logic signed [VW-1:0] tq_lo;
  logic signed [VW-1:0] qmax;
  logic signed [VW-1:0] qmin;

  logic signed [VW-1:0] r;
  logic signed [W-1:0]  c4;
  logic                 clip4;
  logic [COUNT_WIDTH-1:0] total4;
  logic                 end4;

  logic                 q_above;
  logic                 q_below;
  logic signed [VW-1:0] qv;
  logic signed [W-1:0]  out_next;

  assign db       = cap_shift(cfg.quant_bits);
  assign low_mask = (VW'(1) << db) - VW'(1);
  assign keep     = ~low_mask;
  assign half_q   = (db == '0) ? '0 : (VW'(1) << (db - SHIFT_W'(1)));
  assign dz       = VW'($signed(cfg.dst_bias[W-1:0]));
  assign hi       = VW'($signed(cfg.code_ceil[W-1:0]));
  assign lo       = VW'($signed(cfg.code_floor[W-1:0]));

  // whole-step bounds, truncated toward zero
  assign t_hi  = hi - dz;
  assign t_lo  = dz - lo;
  assign tq_hi = t_hi[VW-1] ? ((t_hi + low_mask) & keep) : (t_hi & keep);
  assign tq_lo = t_lo[VW-1] ? ((t_lo + low_mask) & keep) : (t_lo & keep);

  always_ff @(posedge clk) begin
    qmax <= dz + tq_hi;
    qmin <= dz - tq_lo;
  end

  assign off    = VW'(c_in) - dz;
  assign r_next = ((off + half_q) & keep) + dz;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      r      <= r_next;
      c4     <= c_in;
      clip4  <= clipped_in;
      total4 <= total_in;
      end4   <= end_in;
    end
  end

  assign q_above  = r > qmax;
  assign q_below  = r < qmin;
  assign qv       = q_above ? qmax : (q_below ? qmin : r);
  assign out_next = (cfg.quant_bits != '0) ? qv[W-1:0] : c4;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sample_out  <= out_next;
      clipped_out <= clip4;
      total_out   <= total4;
      end_out     <= end4;
    end
  end

endmodule

// ----- hw/rtl/srcq_checker.sv -----
module srcq_checker #(
  parameter int SAMPLE_WIDTH = srcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = srcq_pkg::COUNT_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input logic                           was_clipped,
  input logic [COUNT_WIDTH-1:0]         clip_total
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(sample_out) && $stable(clip_total))
    else $error("stalled result changed");

  a_clip_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid && was_clipped |-> clip_total != '0)
    else $error("clipped item with zero clip total");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    $fell(rst) && !sample_valid |-> !sample_stall)
    else $error("input stalled right after reset");

endmodule

bind sample_rescale_clip_quantize_unit srcq_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_srcq_checker (.*);

// ----- tb/sample_rescale_clip_quantize_unit_tb.sv -----
module sample_rescale_clip_quantize_unit_tb;
  import srcq_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FRAC = GAIN_FRAC_BITS_DEF;
  localparam int CW = COUNT_WIDTH_DEF;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 clipped;
    logic [CW-1:0]        total;
    logic                 last;
  } conv_result_t;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  logic signed [SW-1:0]  sample_in;
  logic                  block_end;
  logic                  result_valid;
  logic                  result_stall;
  logic signed [SW-1:0]  sample_out;
  logic                  was_clipped;
  logic [CW-1:0]         clip_total;
  logic                  block_end_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t          live_cfg;
  logic [CW-1:0] clips_seen;
  conv_result_t  pending_results[$];
  conv_result_t  want;
  int            errors = 0;
  bit            idle_on = 1'b0;
  int            holds_asked = 0;
  int            holds_done = 0;
  int            hold_left = 0;
  int            burst_left = 0;

  sample_rescale_clip_quantize_unit uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_in(sample_in),
    .block_end(block_end),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sample_out(sample_out),
    .was_clipped(was_clipped),
    .clip_total(clip_total),
    .block_end_out(block_end_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_code(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic conv_result_t convert_and_count(input logic signed [SW-1:0] s_in,
                                                     input logic be);
    longint d, v, c, zs, zd, lo, hi, step, qmax, qmin, off, r;
    longint unsigned mag, p, q, rem, half;
    int sh, db;
    bit neg;
    conv_result_t res;
    zs = $signed(live_cfg.src_bias);
    zd = $signed(live_cfg.dst_bias);
    lo = $signed(live_cfg.code_floor);
    hi = $signed(live_cfg.code_ceil);
    d = longint'(s_in) - zs;
    sh = (live_cfg.shift_amount > SHIFT_CAP) ? int'(SHIFT_CAP) : int'(live_cfg.shift_amount);
    case (live_cfg.mode)
      MODE_SHL: v = d * (longint'(1) << sh);
      MODE_SHR: v = (sh == 0) ? d : ((d + (longint'(1) << (sh - 1))) >>> sh);
      MODE_SCALE: begin
        neg = d < 0;
        mag = neg ? -d : d;
        p = mag * {32'd0, live_cfg.gain_q16};
        q = p >> FRAC;
        rem = p & ((64'd1 << FRAC) - 1);
        half = 64'd1 << (FRAC - 1);
        if (rem > half || (rem == half && q[0])) q++;
        v = neg ? -longint'(q) : longint'(q);
      end
      default: v = d;
    endcase
    v += zd;
    c = clamp_code(v, lo, hi);
    res.clipped = (c != v);
    if (res.clipped && clips_seen != '1) clips_seen++;
    if (live_cfg.quant_bits != 0) begin
      db = (live_cfg.quant_bits > SHIFT_CAP) ? int'(SHIFT_CAP) : int'(live_cfg.quant_bits);
      step = longint'(1) << db;
      qmax = zd + ((hi - zd) / step) * step;
      qmin = zd - ((zd - lo) / step) * step;
      off = c - zd;
      r = ((off + (longint'(1) << (db - 1))) >>> db) * step + zd;
      c = clamp_code(r, qmin, qmax);
    end
    res.sample = c[SW-1:0];
    res.total = clips_seen;
    res.last = be;
    return res;
  endfunction

  function automatic cfg_t base_settings();
    cfg_t s;
    s.mode = MODE_COPY;
    s.shift_amount = '0;
    s.gain_q16 = GAIN_RESET;
    s.src_bias = '0;
    s.dst_bias = '0;
    s.code_floor = 32'h8000_0000;
    s.code_ceil = 32'h7FFF_FFFF;
    s.quant_bits = '0;
    return s;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int zd;
    int span;
    s.mode = MODE_W'($urandom_range(0, 3));
    s.shift_amount = SHIFT_W'($urandom_range(0, 31));
    s.gain_q16 = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
    s.src_bias = ($urandom_range(0, 3) == 0) ? $urandom : int'($urandom_range(0, 20000)) - 10000;
    zd = ($urandom_range(0, 3) == 0) ? $urandom : int'($urandom_range(0, 20000)) - 10000;
    s.dst_bias = zd;
    case ($urandom_range(0, 5))
      0: begin
        s.code_floor = 32'h8000_0000;
        s.code_ceil = 32'h7FFF_FFFF;
      end
      1: begin
        s.code_floor = zd + 50;
        s.code_ceil = zd - 50;
      end
      2: begin
        s.code_floor = $urandom;
        s.code_ceil = $urandom;
      end
      default: begin
        span = $urandom_range(0, 1 << 20);
        s.code_floor = zd - span;
        s.code_ceil = zd + int'($urandom_range(0, 1 << 20));
      end
    endcase
    s.quant_bits = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(0, 31));
    return s;
  endfunction

  function automatic int random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1, 2: return int'(live_cfg.src_bias) + int'($urandom_range(0, 4095)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:       live_cfg.mode = val[MODE_W-1:0];
      CFG_SHIFT:      live_cfg.shift_amount = val[SHIFT_W-1:0];
      CFG_GAIN:       live_cfg.gain_q16 = val;
      CFG_SRC_BIAS:   live_cfg.src_bias = val;
      CFG_DST_BIAS:   live_cfg.dst_bias = val;
      CFG_CODE_FLOOR: live_cfg.code_floor = val;
      CFG_CODE_CEIL:  live_cfg.code_ceil = val;
      CFG_QUANT_BITS: live_cfg.quant_bits = val[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CFG_MODE, CFG_DATA_W'(s.mode));
    write_reg(CFG_SHIFT, CFG_DATA_W'(s.shift_amount));
    write_reg(CFG_GAIN, s.gain_q16);
    write_reg(CFG_SRC_BIAS, s.src_bias);
    write_reg(CFG_DST_BIAS, s.dst_bias);
    write_reg(CFG_CODE_FLOOR, s.code_floor);
    write_reg(CFG_CODE_CEIL, s.code_ceil);
    write_reg(CFG_QUANT_BITS, CFG_DATA_W'(s.quant_bits));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input int s, input bit be);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_in <= s;
    block_end <= be;
    do @(posedge clk); while (sample_stall);
    pending_results.push_back(convert_and_count(s, be));
    @(negedge clk);
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_reset_defaults();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b1);
    drain_results();
  endtask

  task automatic test_shifts();
    cfg_t s;
    s = base_settings();
    s.mode = MODE_SHL;
    s.shift_amount = 5'd31;
    load_settings(s);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    drain_results();
    s.mode = MODE_SHR;
    s.shift_amount = 5'd1;
    load_settings(s);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b1);
    drain_results();
    s.shift_amount = 5'd0;
    load_settings(s);
    send_sample(-7, 1'b0);
    drain_results();
    s.shift_amount = 5'd31;
    load_settings(s);
    send_sample(32'h8000_0000, 1'b1);
    drain_results();
  endtask

  task automatic test_scale();
    cfg_t s;
    s = base_settings();
    s.mode = MODE_SCALE;
    s.gain_q16 = 32'h0001_8000;
    load_settings(s);
    send_sample(1, 1'b0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b1);
    drain_results();
    s.gain_q16 = 32'hFFFF_FFFF;
    s.src_bias = 32'h7FFF_FFFF;
    load_settings(s);
    send_sample(32'h8000_0000, 1'b0);
    drain_results();
    s.gain_q16 = '0;
    s.src_bias = '0;
    load_settings(s);
    send_sample(12345, 1'b1);
    drain_results();
  endtask

  task automatic test_zero_and_bounds();
    cfg_t s;
    s = base_settings();
    s.src_bias = 32'h7FFF_FFFF;
    s.dst_bias = 32'h8000_0000;
    load_settings(s);
    send_sample(32'h8000_0000, 1'b1);
    drain_results();
    s = base_settings();
    s.code_floor = 100;
    s.code_ceil = -100;
    load_settings(s);
    send_sample(500, 1'b0);
    send_sample(-500, 1'b1);
    send_sample(0, 1'b0);
    drain_results();
  endtask

  task automatic test_quantize();
    cfg_t s;
    s = base_settings();
    s.dst_bias = 7;
    s.code_floor = -1000;
    s.code_ceil = 1000;
    s.quant_bits = 5'd4;
    load_settings(s);
    send_sample(8, 1'b0);
    send_sample(1000, 1'b1);
    send_sample(-1000, 1'b0);
    drain_results();
    s = base_settings();
    s.quant_bits = 5'd31;
    load_settings(s);
    send_sample(32'h4000_0000, 1'b0);
    send_sample(32'h6000_0000, 1'b1);
    drain_results();
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    repeat (phases) begin
      load_settings(random_settings());
      repeat (per_phase) send_sample(random_sample(), $urandom_range(0, 1));
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    load_settings(random_settings());
    holds_asked++;
    repeat (60) send_sample(random_sample(), $urandom_range(0, 1));
    drain_results();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    load_settings(random_settings());
    repeat (80) send_sample(random_sample(), $urandom_range(0, 1));
    drain_results();
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = 79;
        result_stall <= 1'b1;
      end else if (burst_left > 0) begin
        result_stall <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no sample pending: sample_out %0d", sample_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (sample_out !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
          errors++;
        end
        if (was_clipped !== want.clipped) begin
          $error("was_clipped: expected %0d, got %0d", want.clipped, was_clipped);
          errors++;
        end
        if (clip_total !== want.total) begin
          $error("clip_total: expected %0d, got %0d", want.total, clip_total);
          errors++;
        end
        if (block_end_out !== want.last) begin
          $error("block_end_out: expected %0d, got %0d", want.last, block_end_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample_in = '0;
    block_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    live_cfg = base_settings();
    clips_seen = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_reset_defaults();
    test_shifts();
    test_scale();
    test_zero_and_bounds();
    test_quantize();
    test_random_settings(11, 70);
    test_backpressure();
    test_steady_stream();
    repeat (12) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
